// ----- rtl/vec2_arithmetic_unit_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the 2D vector ALU
// Shared property wrappers, clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef VEC2_ARITHMETIC_UNIT_TOP_MACROS_SVH
`define VEC2_ARITHMETIC_UNIT_TOP_MACROS_SVH

// Same-cycle implication.
`define V2ALU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define V2ALU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/v2alu_pkg.sv -----
// ----------------------------------------------------------------------------
// 2D vector ALU package
// Widths, operation and status codes, the CORDIC angle table and saturation.
// ----------------------------------------------------------------------------
package v2alu_pkg;

  localparam int DW        = 32;       // Q16.16 data width
  localparam int PW        = 64;       // full product width
  localparam int SW        = 66;       // width for sums of two products
  localparam int CW        = 52;       // CORDIC x/y datapath width
  localparam int ZW        = 34;       // CORDIC angle accumulator width
  localparam int QW        = 48;       // dividend and quotient width
  localparam int SQ_STAGES = PW / 2;   // one root bit per stage

  localparam logic [3:0] MODE_ADD    = 4'd0;
  localparam logic [3:0] MODE_SUB    = 4'd1;
  localparam logic [3:0] MODE_SCALE  = 4'd2;
  localparam logic [3:0] MODE_DIV    = 4'd3;
  localparam logic [3:0] MODE_ROTATE = 4'd4;
  localparam logic [3:0] MODE_PERP   = 4'd5;
  localparam logic [3:0] MODE_UNIT   = 4'd6;
  localparam logic [3:0] MODE_DOT    = 4'd7;
  localparam logic [3:0] MODE_CROSS  = 4'd8;
  localparam logic [3:0] MODE_MAG    = 4'd9;
  localparam logic [3:0] MODE_MAGSQ  = 4'd10;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;

  localparam logic signed [DW-1:0] INV_GAIN = 32'sd1304065748;
  localparam logic signed [DW-1:0] I32_MAX  = 32'sh7fffffff;
  localparam logic signed [DW-1:0] I32_MIN  = 32'sh80000000;
  localparam logic signed [SW-1:0] RND_HALF = 66'sd32768;

  typedef struct packed {
    logic [3:0]             mode;
    logic signed [DW-1:0]   ax;
    logic signed [DW-1:0]   ay;
    logic signed [DW-1:0]   s;
    logic signed [DW-1:0]   rx;
    logic signed [DW-1:0]   ry;
    logic signed [DW-1:0]   rs;
    logic [1:0]             st;
  } meta_t;

  // Arctangent of 2^-i in units of 2^32 per turn.
  function automatic logic signed [ZW-1:0] atan_val(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:  v = ZW'(536870912);
      5'd1:  v = ZW'(316933406);
      5'd2:  v = ZW'(167458907);
      5'd3:  v = ZW'(85004756);
      5'd4:  v = ZW'(42667331);
      5'd5:  v = ZW'(21354465);
      5'd6:  v = ZW'(10679838);
      5'd7:  v = ZW'(5340245);
      5'd8:  v = ZW'(2670163);
      5'd9:  v = ZW'(1335087);
      5'd10: v = ZW'(667544);
      5'd11: v = ZW'(333772);
      5'd12: v = ZW'(166886);
      5'd13: v = ZW'(83443);
      5'd14: v = ZW'(41722);
      5'd15: v = ZW'(20861);
      5'd16: v = ZW'(10430);
      5'd17: v = ZW'(5215);
      5'd18: v = ZW'(2608);
      5'd19: v = ZW'(1304);
      5'd20: v = ZW'(652);
      5'd21: v = ZW'(326);
      5'd22: v = ZW'(163);
      5'd23: v = ZW'(81);
      5'd24: v = ZW'(41);
      5'd25: v = ZW'(20);
      5'd26: v = ZW'(10);
      5'd27: v = ZW'(5);
      5'd28: v = ZW'(3);
      5'd29: v = ZW'(1);
      5'd30: v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  // True when a wide value lies outside the signed 32-bit range.
  function automatic logic ovf32(input logic signed [SW-1:0] v);
    return !((&v[SW-1:DW-1]) || !(|v[SW-1:DW-1]));
  endfunction

  function automatic logic signed [DW-1:0] sat32(input logic signed [SW-1:0] v);
    logic signed [DW-1:0] r;
    if (ovf32(v)) begin
      r = v[SW-1] ? I32_MIN : I32_MAX;
    end else begin
      r = v[DW-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/v2alu_sqrt.sv -----
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root of a 64-bit value, one result bit per stage.
// ----------------------------------------------------------------------------
module v2alu_sqrt
  import v2alu_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  input  logic [PW-1:0] in_val,
  input  meta_t         in_meta,
  output logic          out_vld,
  output logic [DW-1:0] out_root,
  output meta_t         out_meta
);

  logic [PW-1:0]        v_r    [SQ_STAGES];
  logic [PW-1:0]        r_r    [SQ_STAGES];
  meta_t                meta_r [SQ_STAGES];
  logic [SQ_STAGES-1:0] vld_r;

  logic [PW-1:0]        v_i    [SQ_STAGES];
  logic [PW-1:0]        r_i    [SQ_STAGES];
  meta_t                meta_i [SQ_STAGES];
  logic [PW-1:0]        bit_c  [SQ_STAGES];

  function automatic logic [2*PW-1:0] sq_step(input logic [PW-1:0] v,
                                              input logic [PW-1:0] r,
                                              input logic [PW-1:0] b);
    logic [PW-1:0] t;
    logic [2*PW-1:0] res;
    t = r + b;
    if (v >= t) begin
      res = {v - t, (r >> 1) + b};
    end else begin
      res = {v, r >> 1};
    end
    return res;
  endfunction

  for (genvar j = 0; j < SQ_STAGES; j++) begin : g_stage
    assign bit_c[j] = PW'(1) << (PW - 2 - 2 * j);
    if (j == 0) begin : g_first
      assign v_i[j]    = in_val;
      assign r_i[j]    = '0;
      assign meta_i[j] = in_meta;
    end else begin : g_next
      assign v_i[j]    = v_r[j-1];
      assign r_i[j]    = r_r[j-1];
      assign meta_i[j] = meta_r[j-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < SQ_STAGES; j++) begin
      {v_r[j], r_r[j]} <= sq_step(v_i[j], r_i[j], bit_c[j]);
      meta_r[j]        <= meta_i[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[SQ_STAGES-2:0], in_vld};
    end
  end

  assign out_vld  = vld_r[SQ_STAGES-1];
  assign out_root = r_r[SQ_STAGES-1][DW-1:0];
  assign out_meta = meta_r[SQ_STAGES-1];

endmodule

// ----- rtl/v2alu_cordic.sv -----
// ----------------------------------------------------------------------------
// Pipelined CORDIC rotator
// Rotation-mode CORDIC, one micro-rotation per stage, padded to the root depth.
// ----------------------------------------------------------------------------
module v2alu_cordic
  import v2alu_pkg::*;
#(
  parameter int STEPS = 16
) (
  input  logic                 clk,
  input  logic signed [CW-1:0] in_x,
  input  logic signed [CW-1:0] in_y,
  input  logic signed [ZW-1:0] in_z,
  output logic signed [CW-1:0] out_x,
  output logic signed [CW-1:0] out_y
);

  logic signed [CW-1:0] x_r [SQ_STAGES];
  logic signed [CW-1:0] y_r [SQ_STAGES];
  logic signed [ZW-1:0] z_r [SQ_STAGES];
  logic signed [CW-1:0] x_i [SQ_STAGES];
  logic signed [CW-1:0] y_i [SQ_STAGES];
  logic signed [ZW-1:0] z_i [SQ_STAGES];

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign x_i[k] = in_x;
      assign y_i[k] = in_y;
      assign z_i[k] = in_z;
    end else begin : g_next
      assign x_i[k] = x_r[k-1];
      assign y_i[k] = y_r[k-1];
      assign z_i[k] = z_r[k-1];
    end
  end

  // Stages past the configured step count only carry the vector forward.
  always_ff @(posedge clk) begin
    for (int k = 0; k < SQ_STAGES; k++) begin
      if (k < STEPS) begin
        if (!z_i[k][ZW-1]) begin
          x_r[k] <= x_i[k] - (y_i[k] >>> k);
          y_r[k] <= y_i[k] + (x_i[k] >>> k);
          z_r[k] <= z_i[k] - atan_val(5'(k));
        end else begin
          x_r[k] <= x_i[k] + (y_i[k] >>> k);
          y_r[k] <= y_i[k] - (x_i[k] >>> k);
          z_r[k] <= z_i[k] + atan_val(5'(k));
        end
      end else begin
        x_r[k] <= x_i[k];
        y_r[k] <= y_i[k];
        z_r[k] <= z_i[k];
      end
    end
  end

  assign out_x = x_r[SQ_STAGES-1];
  assign out_y = y_r[SQ_STAGES-1];

endmodule

// ----- rtl/v2alu_div.sv -----
// ----------------------------------------------------------------------------
// Pipelined two-lane divider
// Restoring division of two 48-bit magnitudes by one shared 32-bit divisor.
// ----------------------------------------------------------------------------
module v2alu_div
  import v2alu_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  logic [1:0][QW-1:0]  in_num,
  input  logic [DW-1:0]       in_den,
  input  meta_t               in_meta,
  output logic                out_vld,
  output logic [1:0][QW-1:0]  out_quo,
  output meta_t               out_meta
);

  logic [DW-1:0] rem_r  [QW][2];
  logic [QW-1:0] nq_r   [QW][2];
  logic [DW-1:0] den_r  [QW];
  meta_t         meta_r [QW];
  logic [QW-1:0] vld_r;

  logic [DW-1:0] rem_i  [QW][2];
  logic [QW-1:0] nq_i   [QW][2];
  logic [DW-1:0] den_i  [QW];
  meta_t         meta_i [QW];

  // Dividend and quotient bits share one shifting word per lane.
  function automatic logic [DW+QW-1:0] div_step(input logic [DW-1:0] rem,
                                                input logic [QW-1:0] nq,
                                                input logic [DW-1:0] den);
    logic [DW:0] t;
    logic [DW:0] diff;
    logic        ge;
    t    = {rem, nq[QW-1]};
    diff = t - {1'b0, den};
    ge   = (t >= {1'b0, den});
    return {(ge ? diff[DW-1:0] : t[DW-1:0]), nq[QW-2:0], ge};
  endfunction

  for (genvar k = 0; k < QW; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign den_i[k]  = in_den;
      assign meta_i[k] = in_meta;
      for (genvar l = 0; l < 2; l++) begin : g_lane
        assign rem_i[k][l] = '0;
        assign nq_i[k][l]  = in_num[l];
      end
    end else begin : g_next
      assign den_i[k]  = den_r[k-1];
      assign meta_i[k] = meta_r[k-1];
      for (genvar l = 0; l < 2; l++) begin : g_lane
        assign rem_i[k][l] = rem_r[k-1][l];
        assign nq_i[k][l]  = nq_r[k-1][l];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QW; k++) begin
      for (int l = 0; l < 2; l++) begin
        {rem_r[k][l], nq_r[k][l]} <= div_step(rem_i[k][l], nq_i[k][l], den_i[k]);
      end
      den_r[k]  <= den_i[k];
      meta_r[k] <= meta_i[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[QW-2:0], in_vld};
    end
  end

  assign out_vld    = vld_r[QW-1];
  assign out_quo[0] = nq_r[QW-1][0];
  assign out_quo[1] = nq_r[QW-1][1];
  assign out_meta   = meta_r[QW-1];

endmodule

// ----- rtl/vec2_arithmetic_unit_top.sv -----
// ----------------------------------------------------------------------------
// 2D vector ALU, signed Q16.16
// Fully pipelined vector arithmetic: add, sub, scale, divide, rotate, perp,
// unit, dot, cross, magnitude and squared magnitude.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction enters when start is high and busy is low. busy is always
//   low: the unit is a fixed-latency pipeline and takes one transaction in
//   every clock cycle, back to back, with no gaps needed between them.
//   Each result appears on out_r_x, out_r_y, out_r_scalar and out_status for
//   exactly one cycle, marked by out_valid. The receiver cannot stall the
//   unit, so it must take every result in the cycle it is shown.
//   Every operation passes through one input register, one multiply stage,
//   one rounding stage, 32 square-root stages (the rotator runs beside
//   them), one divider setup stage, 48 divider stages and one output
//   register. The 48-bit quotient, one bit per stage, sets the depth.
//   Results leave in the order the transactions arrived.
//   A synchronous reset (rst_n low) clears every valid bit, so all
//   transactions still in flight are dropped; no clearing pass is needed.
// ----------------------------------------------------------------------------
module vec2_arithmetic_unit_top
  import v2alu_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [3:0]           in_mode,
  input  logic signed [DW-1:0] in_a_x,
  input  logic signed [DW-1:0] in_a_y,
  input  logic signed [DW-1:0] in_b_x,
  input  logic signed [DW-1:0] in_b_y,
  input  logic signed [DW-1:0] in_scalar,
  input  logic [15:0]          in_angle,
  output logic                 out_valid,
  output logic signed [DW-1:0] out_r_x,
  output logic signed [DW-1:0] out_r_y,
  output logic signed [DW-1:0] out_r_scalar,
  output logic [1:0]           out_status
);

`include "vec2_arithmetic_unit_top_macros.svh"

  localparam int PIPE_LAT = 3 + SQ_STAGES + 1 + QW + 1;

  // --------------------------------------------------------------------------
  // Stage A: input register.
  // --------------------------------------------------------------------------
  logic                 a_vld_r;
  logic [3:0]           a_mode_r;
  logic signed [DW-1:0] a_ax_r, a_ay_r, a_bx_r, a_by_r, a_s_r;
  logic [15:0]          a_ang_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    a_mode_r <= in_mode;
    a_ax_r   <= in_a_x;
    a_ay_r   <= in_a_y;
    a_bx_r   <= in_b_x;
    a_by_r   <= in_b_y;
    a_s_r    <= in_scalar;
    a_ang_r  <= in_angle;
  end

  // --------------------------------------------------------------------------
  // Stage B: one multiplier per lane. The x lane always multiplies a_x and the
  // y lane a_y; the second operand depends on the operation. Rotation uses
  // the inverse CORDIC gain here and applies the quarter turn afterwards.
  // --------------------------------------------------------------------------
  logic                 b_vld_r;
  logic [3:0]           b_mode_r;
  logic signed [DW-1:0] b_ax_r, b_ay_r, b_bx_r, b_by_r, b_s_r;
  logic [15:0]          b_ang_r;
  logic signed [PW-1:0] b_px_r, b_py_r;
  logic signed [DW-1:0] opx, opy;
  logic signed [PW-1:0] b_px_nxt, b_py_nxt;

  always_comb begin
    case (a_mode_r)
      MODE_SCALE: begin
        opx = a_s_r;
        opy = a_s_r;
      end
      MODE_DOT: begin
        opx = a_bx_r;
        opy = a_by_r;
      end
      MODE_CROSS: begin
        opx = a_by_r;
        opy = a_bx_r;
      end
      MODE_ROTATE: begin
        opx = INV_GAIN;
        opy = INV_GAIN;
      end
      default: begin
        opx = a_ax_r;
        opy = a_ay_r;
      end
    endcase
  end

  assign b_px_nxt = PW'(a_ax_r) * PW'(opx);
  assign b_py_nxt = PW'(a_ay_r) * PW'(opy);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    b_mode_r <= a_mode_r;
    b_ax_r   <= a_ax_r;
    b_ay_r   <= a_ay_r;
    b_bx_r   <= a_bx_r;
    b_by_r   <= a_by_r;
    b_s_r    <= a_s_r;
    b_ang_r  <= a_ang_r;
    b_px_r   <= b_px_nxt;
    b_py_r   <= b_py_nxt;
  end

  // --------------------------------------------------------------------------
  // Stage C: finish add, sub, scale, perp, dot, cross and squared magnitude,
  // form the sum of squares for the root and set up the rotator.
  // --------------------------------------------------------------------------
  logic                 c_vld_r;
  meta_t                c_meta_r, c_meta_nxt;
  logic [PW-1:0]        c_sq_r, c_sq_nxt;
  logic signed [CW-1:0] c_x_r, c_y_r, c_x_nxt, c_y_nxt;
  logic signed [ZW-1:0] c_z_r, c_z_nxt;

  logic signed [SW-1:0] add_x, add_y, sub_x, sub_y, scl_x, scl_y;
  logic signed [SW-1:0] pxe, pye, dot_v, crs_v, perp_v;
  logic [PW-1:0]        msq_t;
  logic [PW-16:0]       msq_v;
  logic [15:0]          ang_q, ang_res;
  logic [1:0]           quad;
  logic signed [PW-1:0] rot_x, rot_y, rot_xs, rot_ys;

  assign pxe    = SW'(b_px_r);
  assign pye    = SW'(b_py_r);
  assign add_x  = SW'(b_ax_r) + SW'(b_bx_r);
  assign add_y  = SW'(b_ay_r) + SW'(b_by_r);
  assign sub_x  = SW'(b_ax_r) - SW'(b_bx_r);
  assign sub_y  = SW'(b_ay_r) - SW'(b_by_r);
  assign scl_x  = (pxe + RND_HALF) >>> 16;
  assign scl_y  = (pye + RND_HALF) >>> 16;
  assign dot_v  = (pxe + pye + RND_HALF) >>> 16;
  assign crs_v  = (pxe - pye + RND_HALF) >>> 16;
  assign perp_v = -SW'(b_ay_r);

  // Both products are squares here, so the unsigned sum cannot wrap.
  assign c_sq_nxt = $unsigned(b_px_r) + $unsigned(b_py_r);
  assign msq_t    = {1'b0, c_sq_nxt[PW-1:1]} + PW'(16384);
  assign msq_v    = msq_t[PW-1:15];

  // Nearest quarter turn and the signed remainder in [-1/8, 1/8) turn.
  assign ang_q   = b_ang_r + 16'h2000;
  assign quad    = ang_q[15:14];
  assign ang_res = b_ang_r - {quad, 14'd0};
  assign c_z_nxt = {{(ZW-32){ang_res[15]}}, ang_res, 16'd0};

  always_comb begin
    case (quad)
      2'd1: begin
        rot_x = -b_py_r;
        rot_y = b_px_r;
      end
      2'd2: begin
        rot_x = -b_px_r;
        rot_y = -b_py_r;
      end
      2'd3: begin
        rot_x = b_py_r;
        rot_y = -b_px_r;
      end
      default: begin
        rot_x = b_px_r;
        rot_y = b_py_r;
      end
    endcase
  end

  assign rot_xs  = rot_x >>> 15;
  assign rot_ys  = rot_y >>> 15;
  assign c_x_nxt = rot_xs[CW-1:0];
  assign c_y_nxt = rot_ys[CW-1:0];

  always_comb begin
    c_meta_nxt      = '0;
    c_meta_nxt.mode = b_mode_r;
    c_meta_nxt.ax   = b_ax_r;
    c_meta_nxt.ay   = b_ay_r;
    c_meta_nxt.s    = b_s_r;
    case (b_mode_r)
      MODE_ADD: begin
        c_meta_nxt.rx = sat32(add_x);
        c_meta_nxt.ry = sat32(add_y);
        c_meta_nxt.st = (ovf32(add_x) || ovf32(add_y)) ? ST_SAT : ST_OK;
      end
      MODE_SUB: begin
        c_meta_nxt.rx = sat32(sub_x);
        c_meta_nxt.ry = sat32(sub_y);
        c_meta_nxt.st = (ovf32(sub_x) || ovf32(sub_y)) ? ST_SAT : ST_OK;
      end
      MODE_SCALE: begin
        c_meta_nxt.rx = sat32(scl_x);
        c_meta_nxt.ry = sat32(scl_y);
        c_meta_nxt.st = (ovf32(scl_x) || ovf32(scl_y)) ? ST_SAT : ST_OK;
      end
      MODE_PERP: begin
        c_meta_nxt.rx = sat32(perp_v);
        c_meta_nxt.ry = b_ax_r;
        c_meta_nxt.st = ovf32(perp_v) ? ST_SAT : ST_OK;
      end
      MODE_DOT: begin
        c_meta_nxt.rs = sat32(dot_v);
        c_meta_nxt.st = ovf32(dot_v) ? ST_SAT : ST_OK;
      end
      MODE_CROSS: begin
        c_meta_nxt.rs = sat32(crs_v);
        c_meta_nxt.st = ovf32(crs_v) ? ST_SAT : ST_OK;
      end
      MODE_MAGSQ: begin
        if (|msq_v[PW-16:DW-1]) begin
          c_meta_nxt.rs = I32_MAX;
          c_meta_nxt.st = ST_SAT;
        end else begin
          c_meta_nxt.rs = $signed(msq_v[DW-1:0]);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    c_meta_r <= c_meta_nxt;
    c_sq_r   <= c_sq_nxt;
    c_x_r    <= c_x_nxt;
    c_y_r    <= c_y_nxt;
    c_z_r    <= c_z_nxt;
  end

  // --------------------------------------------------------------------------
  // Square root and rotator run side by side with equal depth.
  // --------------------------------------------------------------------------
  logic                 sq_vld;
  logic [DW-1:0]        sq_root;
  meta_t                sq_meta;
  logic signed [CW-1:0] cr_x, cr_y;

  v2alu_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (c_vld_r),
    .in_val   (c_sq_r),
    .in_meta  (c_meta_r),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_meta (sq_meta)
  );

  v2alu_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .in_x  (c_x_r),
    .in_y  (c_y_r),
    .in_z  (c_z_r),
    .out_x (cr_x),
    .out_y (cr_y)
  );

  // --------------------------------------------------------------------------
  // Stage D: round the rotation, finish the magnitude and set up the divider.
  // Divide uses |scalar| as divisor, unit uses the magnitude.
  // --------------------------------------------------------------------------
  logic                 d_vld_r;
  meta_t                d_meta_r, d_meta_nxt;
  logic [1:0][QW-1:0]   d_num_r, d_num_nxt;
  logic [DW-1:0]        d_den_r, d_den_nxt;
  logic signed [SW-1:0] rnd_x, rnd_y;
  logic [DW-1:0]        abs_x, abs_y, abs_s;

  assign rnd_x = (SW'(cr_x) + RND_HALF) >>> 16;
  assign rnd_y = (SW'(cr_y) + RND_HALF) >>> 16;
  assign abs_x = sq_meta.ax[DW-1] ? DW'(-sq_meta.ax) : sq_meta.ax;
  assign abs_y = sq_meta.ay[DW-1] ? DW'(-sq_meta.ay) : sq_meta.ay;
  assign abs_s = sq_meta.s[DW-1]  ? DW'(-sq_meta.s)  : sq_meta.s;

  assign d_num_nxt[0] = {abs_x, 16'd0};
  assign d_num_nxt[1] = {abs_y, 16'd0};
  assign d_den_nxt    = (sq_meta.mode == MODE_DIV) ? abs_s : sq_root;

  always_comb begin
    d_meta_nxt = sq_meta;
    case (sq_meta.mode)
      MODE_ROTATE: begin
        d_meta_nxt.rx = sat32(rnd_x);
        d_meta_nxt.ry = sat32(rnd_y);
        d_meta_nxt.st = (ovf32(rnd_x) || ovf32(rnd_y)) ? ST_SAT : ST_OK;
      end
      MODE_MAG: begin
        if (sq_root[DW-1]) begin
          d_meta_nxt.rs = I32_MAX;
          d_meta_nxt.st = ST_SAT;
        end else begin
          d_meta_nxt.rs = $signed(sq_root);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else begin
      d_vld_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    d_meta_r <= d_meta_nxt;
    d_num_r  <= d_num_nxt;
    d_den_r  <= d_den_nxt;
  end

  // --------------------------------------------------------------------------
  // Divider lanes for x and y.
  // --------------------------------------------------------------------------
  logic               dv_vld;
  logic [1:0][QW-1:0] dv_quo;
  meta_t              dv_meta;

  v2alu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (d_vld_r),
    .in_num   (d_num_r),
    .in_den   (d_den_r),
    .in_meta  (d_meta_r),
    .out_vld  (dv_vld),
    .out_quo  (dv_quo),
    .out_meta (dv_meta)
  );

  // --------------------------------------------------------------------------
  // Stage E: merge. Quotient lanes get their sign back and saturate; every
  // other operation passes its finished result through.
  // --------------------------------------------------------------------------
  logic signed [SW-1:0] qx_v, qy_v;
  logic signed [DW-1:0] e_rx_nxt, e_ry_nxt, e_rs_nxt;
  logic [1:0]           e_st_nxt;
  logic                 q_ovf;
  logic                 q_negs;

  // Divide-by-zero clamp follows the sign of the numerator.
  function automatic logic signed [DW-1:0] divz_val(input logic signed [DW-1:0] a);
    logic signed [DW-1:0] r;
    if (a[DW-1]) begin
      r = I32_MIN;
    end else if (|a) begin
      r = I32_MAX;
    end else begin
      r = '0;
    end
    return r;
  endfunction

  // A negative divisor flips the quotient sign; the magnitude is never negative.
  assign q_negs = (dv_meta.mode == MODE_DIV) && dv_meta.s[DW-1];
  assign qx_v   = (dv_meta.ax[DW-1] ^ q_negs) ? -$signed(SW'(dv_quo[0]))
                                              : $signed(SW'(dv_quo[0]));
  assign qy_v   = (dv_meta.ay[DW-1] ^ q_negs) ? -$signed(SW'(dv_quo[1]))
                                              : $signed(SW'(dv_quo[1]));
  assign q_ovf  = ovf32(qx_v) || ovf32(qy_v);

  always_comb begin
    e_rx_nxt = dv_meta.rx;
    e_ry_nxt = dv_meta.ry;
    e_rs_nxt = dv_meta.rs;
    e_st_nxt = dv_meta.st;
    case (dv_meta.mode)
      MODE_DIV: begin
        if (dv_meta.s == '0) begin
          e_rx_nxt = divz_val(dv_meta.ax);
          e_ry_nxt = divz_val(dv_meta.ay);
          e_st_nxt = ST_DIVZ;
        end else begin
          e_rx_nxt = sat32(qx_v);
          e_ry_nxt = sat32(qy_v);
          e_st_nxt = q_ovf ? ST_SAT : ST_OK;
        end
      end
      MODE_UNIT: begin
        // A zero vector has a zero root and gives the zero vector.
        if (dv_meta.ax == '0 && dv_meta.ay == '0) begin
          e_rx_nxt = '0;
          e_ry_nxt = '0;
          e_st_nxt = ST_OK;
        end else begin
          e_rx_nxt = sat32(qx_v);
          e_ry_nxt = sat32(qy_v);
          e_st_nxt = q_ovf ? ST_SAT : ST_OK;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_r_x      <= e_rx_nxt;
    out_r_y      <= e_ry_nxt;
    out_r_scalar <= e_rs_nxt;
    out_status   <= e_st_nxt;
  end

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  `V2ALU_ASSERT_IMP(a_out_lat, out_valid, $past(start, PIPE_LAT), "result without a transaction at fixed latency")
  `V2ALU_ASSERT_NXT(a_in_take, start, a_vld_r, "accepted transaction did not enter the pipeline")
  `V2ALU_ASSERT_IMP(a_vec_scl, out_valid && (out_r_x != '0 || out_r_y != '0), out_r_scalar == '0, "vector and scalar result both set")
  `V2ALU_ASSERT_IMP(a_divz, out_valid && out_status == ST_DIVZ, out_r_scalar == '0, "divide by zero with a scalar result")

endmodule
